/* rtl/core/q31_overlap_window_core_defines.svh */
// Assertion macros for the Q31 overlap window core
`ifndef Q31_OVERLAP_WINDOW_CORE_DEFINES_SVH
`define Q31_OVERLAP_WINDOW_CORE_DEFINES_SVH

// Same-cycle implication, off during reset
`define Q31OW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define Q31OW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked through reset as well
`define Q31OW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/q31ow_pkg.sv */
`default_nettype none
package q31ow_pkg;

   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int Q31_SHIFT = 31;
   localparam int RES_W     = SUM_W - Q31_SHIFT;
   localparam int SHIFT_W   = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = SHIFT_W;
   localparam int OUT_W     = 16;
   localparam int SAT_MAX   = 32767;
   localparam int SAT_MIN   = -32768;
   localparam int PIPE_DEPTH = 4;
   localparam int CNT_W     = $clog2(PIPE_DEPTH + 1);

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'h0000_0000_4000_0000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALED_MODE  = 1'b0,
      CSR_OUTPUT_SHIFT = 1'b1
   } csr_index_type;

endpackage
`default_nettype wire

/* rtl/core/q31_overlap_window_core.sv */
`default_nettype none
// Q31 overlap-add window: each word carries a sample pair and its two mirrored
// window coefficients and returns front = s0*wj - s1*wi and back = s0*wi + s1*wj,
// both rounded by 2^30 and shifted right 31, then either wrapped to 32 bits or
// (scaled mode) given a rounded right shift by output_shift and saturated to int16.
// The core takes one word per cycle unless a result-side stall backs up to it.
// The input register captures the word at the accepting edge; the word then passes
// the product, sum and result registers before rsp_valid rises, a depth set by the
// four 32x32 multipliers and the 65-bit sums behind them.
// A stall on the result side backs up through the four stages, so up to 4 words
// can be in flight. csr_ready is always high; write the registers only while idle.
module q31_overlap_window_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [q31ow_pkg::DATA_W-1:0]  req_first_sample,
   input  wire logic signed [q31ow_pkg::DATA_W-1:0]  req_second_sample,
   input  wire logic signed [q31ow_pkg::DATA_W-1:0]  req_window_rising,
   input  wire logic signed [q31ow_pkg::DATA_W-1:0]  req_window_falling,
   input  wire logic                                 req_end_of_block,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [q31ow_pkg::DATA_W-1:0]       rsp_out_front,
   output logic signed [q31ow_pkg::DATA_W-1:0]       rsp_out_back,
   output logic                                      rsp_end_of_block_out,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [q31ow_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [q31ow_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DATA_W  = q31ow_pkg::DATA_W;
   localparam int PROD_W  = q31ow_pkg::PROD_W;
   localparam int SUM_W   = q31ow_pkg::SUM_W;
   localparam int RES_W   = q31ow_pkg::RES_W;
   localparam int SHIFT_W = q31ow_pkg::SHIFT_W;
   localparam int OUT_W   = q31ow_pkg::OUT_W;

   // configuration
   logic               scaled_mode_ff;
   logic [SHIFT_W-1:0] output_shift_ff;

   // stage valids
   logic v_in_ff, v_prod_ff, v_sum_ff, v_out_ff;
   logic adv_in, adv_prod, adv_sum, adv_out;

   // input stage
   logic signed [DATA_W-1:0] s0_ff, s1_ff, wi_ff, wj_ff;
   logic                     eob_in_ff;

   // product stage
   logic signed [PROD_W-1:0] p_s0wj_ff, p_s1wi_ff, p_s0wi_ff, p_s1wj_ff;
   logic signed [PROD_W-1:0] p_s0wj_in, p_s1wi_in, p_s0wi_in, p_s1wj_in;
   logic                     eob_prod_ff;

   // sum stage
   logic signed [SUM_W-1:0]  front_sum_in, back_sum_in;
   logic signed [RES_W-1:0]  front_r_ff, back_r_ff;
   logic                     eob_sum_ff;

   // result stage
   logic signed [DATA_W-1:0] front_ff, back_ff, front_in, back_in;
   logic                     eob_out_ff;

   function automatic logic signed [DATA_W-1:0] finish_word(
      input logic signed [RES_W-1:0] r,
      input logic                    scaled,
      input logic [SHIFT_W-1:0]      sh
   );
      logic [RES_W:0]        rnd;
      logic signed [RES_W:0] biased;
      logic signed [RES_W:0] shifted;
      logic signed [OUT_W-1:0] sat;
      rnd     = ((RES_W+1)'(1) << sh) >> 1;
      biased  = (RES_W+1)'(r) + rnd;
      shifted = biased >>> sh;
      if (shifted > (RES_W+1)'(q31ow_pkg::SAT_MAX)) begin
         sat = OUT_W'(q31ow_pkg::SAT_MAX);
      end else if (shifted < (RES_W+1)'(q31ow_pkg::SAT_MIN)) begin
         sat = OUT_W'(q31ow_pkg::SAT_MIN);
      end else begin
         sat = shifted[OUT_W-1:0];
      end
      if (scaled) begin
         finish_word = DATA_W'(sat);
      end else begin
         finish_word = r[DATA_W-1:0];
      end
   endfunction

   // a stage moves on when the stage after it is empty or moving
   assign adv_out  = !v_out_ff || !rsp_stall;
   assign adv_sum  = !v_sum_ff || adv_out;
   assign adv_prod = !v_prod_ff || adv_sum;
   assign adv_in   = !v_in_ff || adv_prod;

   assign req_stall = !adv_in;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scaled_mode_ff  <= 1'b0;
         output_shift_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (q31ow_pkg::csr_index_type'(csr_index))
            q31ow_pkg::CSR_SCALED_MODE:  scaled_mode_ff  <= csr_wdata[0];
            q31ow_pkg::CSR_OUTPUT_SHIFT: output_shift_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff   <= 1'b0;
         v_prod_ff <= 1'b0;
         v_sum_ff  <= 1'b0;
         v_out_ff  <= 1'b0;
      end else begin
         if (adv_in)   v_in_ff   <= req_valid;
         if (adv_prod) v_prod_ff <= v_in_ff;
         if (adv_sum)  v_sum_ff  <= v_prod_ff;
         if (adv_out)  v_out_ff  <= v_sum_ff;
      end
   end

   assign p_s0wj_in = s0_ff * wj_ff;
   assign p_s1wi_in = s1_ff * wi_ff;
   assign p_s0wi_in = s0_ff * wi_ff;
   assign p_s1wj_in = s1_ff * wj_ff;

   // exact 65-bit sums with the Q31 rounding half folded in
   assign front_sum_in = SUM_W'(p_s0wj_ff) - SUM_W'(p_s1wi_ff) + q31ow_pkg::ROUND_HALF;
   assign back_sum_in  = SUM_W'(p_s0wi_ff) + SUM_W'(p_s1wj_ff) + q31ow_pkg::ROUND_HALF;

   assign front_in = finish_word(front_r_ff, scaled_mode_ff, output_shift_ff);
   assign back_in  = finish_word(back_r_ff, scaled_mode_ff, output_shift_ff);

   always_ff @(posedge clock) begin
      if (adv_in && req_valid) begin
         s0_ff     <= req_first_sample;
         s1_ff     <= req_second_sample;
         wi_ff     <= req_window_rising;
         wj_ff     <= req_window_falling;
         eob_in_ff <= req_end_of_block;
      end
      if (adv_prod && v_in_ff) begin
         p_s0wj_ff   <= p_s0wj_in;
         p_s1wi_ff   <= p_s1wi_in;
         p_s0wi_ff   <= p_s0wi_in;
         p_s1wj_ff   <= p_s1wj_in;
         eob_prod_ff <= eob_in_ff;
      end
      if (adv_sum && v_prod_ff) begin
         front_r_ff <= front_sum_in[SUM_W-1:q31ow_pkg::Q31_SHIFT];
         back_r_ff  <= back_sum_in[SUM_W-1:q31ow_pkg::Q31_SHIFT];
         eob_sum_ff <= eob_prod_ff;
      end
      if (adv_out && v_sum_ff) begin
         front_ff   <= front_in;
         back_ff    <= back_in;
         eob_out_ff <= eob_sum_ff;
      end
   end

   assign rsp_valid            = v_out_ff;
   assign rsp_out_front        = front_ff;
   assign rsp_out_back         = back_ff;
   assign rsp_end_of_block_out = eob_out_ff;

endmodule
`default_nettype wire

/* rtl/core/q31ow_checker.sv */
`default_nettype none
`include "q31_overlap_window_core_defines.svh"
module q31ow_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic signed [q31ow_pkg::DATA_W-1:0]  rsp_out_front,
   input wire logic signed [q31ow_pkg::DATA_W-1:0]  rsp_out_back,
   input wire logic                                 rsp_end_of_block_out,
   input wire logic                                 csr_valid,
   input wire logic                                 csr_ready,
   input wire logic [q31ow_pkg::CSR_IDX_W-1:0]      csr_index,
   input wire logic [q31ow_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DATA_W = q31ow_pkg::DATA_W;
   localparam int OUT_W  = q31ow_pkg::OUT_W;
   localparam int CNT_W  = q31ow_pkg::CNT_W;

   logic             scaled_ff;
   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             in_word, out_word;
   logic             front_fits, back_fits;

   assign in_word  = req_valid && !req_stall;
   assign out_word = rsp_valid && !rsp_stall;

   // track words taken but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (in_word && !out_word) begin
         pending_in = pending_ff + CNT_W'(1);
      end else if (out_word && !in_word) begin
         pending_in = pending_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         scaled_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (csr_valid && csr_ready &&
             csr_index == q31ow_pkg::CSR_SCALED_MODE) begin
            scaled_ff <= csr_wdata[0];
         end
      end
   end

   assign front_fits = (&rsp_out_front[DATA_W-1:OUT_W-1]) || !(|rsp_out_front[DATA_W-1:OUT_W-1]);
   assign back_fits  = (&rsp_out_back[DATA_W-1:OUT_W-1]) || !(|rsp_out_back[DATA_W-1:OUT_W-1]);

   `Q31OW_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")
   `Q31OW_ASSERT_NOW(a_no_phantom, clock, reset, rsp_valid, (pending_ff != '0) && (pending_ff <= CNT_W'(q31ow_pkg::PIPE_DEPTH)), "result without a pending word or too many in flight")
   `Q31OW_ASSERT_NOW(a_scaled_range, clock, reset, rsp_valid && scaled_ff, front_fits && back_fits, "scaled result outside int16 range")
   `Q31OW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_front) && $stable(rsp_out_back) && $stable(rsp_end_of_block_out), "stalled result changed")

endmodule

bind q31_overlap_window_core q31ow_checker u_q31ow_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_out_front        (rsp_out_front),
   .rsp_out_back         (rsp_out_back),
   .rsp_end_of_block_out (rsp_end_of_block_out),
   .csr_valid            (csr_valid),
   .csr_ready            (csr_ready),
   .csr_index            (csr_index),
   .csr_wdata            (csr_wdata)
);
`default_nettype wire

/* tb/sv/testbench.sv */
module testbench;
   import q31ow_pkg::*;

   localparam int ACC_W = SUM_W + 1;
   localparam logic signed [ACC_W-1:0] ROUND_Q31 = 1 <<< (Q31_SHIFT - 1);
   localparam logic [DATA_W-1:0] Q31_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] Q31_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] Q15_ONE = 32'h0000_8000;

   typedef struct packed {
      logic [DATA_W-1:0] front;
      logic [DATA_W-1:0] back;
      logic              eob;
   } window_pair;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [DATA_W-1:0]     req_first_sample;
   logic signed [DATA_W-1:0]     req_second_sample;
   logic signed [DATA_W-1:0]     req_window_rising;
   logic signed [DATA_W-1:0]     req_window_falling;
   logic                         req_end_of_block;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [DATA_W-1:0]     rsp_out_front;
   logic signed [DATA_W-1:0]     rsp_out_back;
   logic                         rsp_end_of_block_out;
   logic                         csr_valid;
   logic                         csr_ready;
   csr_index_type                csr_index;
   logic [CSR_DATA_W-1:0]        csr_wdata;

   // shadow copy of the block's registers
   logic                         cfg_scaled;
   logic [SHIFT_W-1:0]           cfg_shift;

   window_pair                   expected_pairs[$];
   bit                           sender_gaps_on;
   bit                           stall_gaps_on;
   int                           error_count;
   int                           pairs_sent;
   int                           scaled_sent;
   int                           pairs_checked;
   int                           settings_used;
   int                           block_slot;

   q31_overlap_window_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_first_sample     (req_first_sample),
      .req_second_sample    (req_second_sample),
      .req_window_rising    (req_window_rising),
      .req_window_falling   (req_window_falling),
      .req_end_of_block     (req_end_of_block),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_front        (rsp_out_front),
      .rsp_out_back         (rsp_out_back),
      .rsp_end_of_block_out (rsp_end_of_block_out),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [DATA_W-1:0] scale_result(input logic signed [ACC_W-1:0] r);
      logic signed [ACC_W-1:0] bias;
      logic signed [ACC_W-1:0] v;
      if (!cfg_scaled)
         return r[DATA_W-1:0];
      bias = '0;
      if (cfg_shift != 0)
         bias = ACC_W'(1) <<< (cfg_shift - 1);
      v = (r + bias) >>> cfg_shift;
      if (v > SAT_MAX)
         v = SAT_MAX;
      else if (v < SAT_MIN)
         v = SAT_MIN;
      return v[DATA_W-1:0];
   endfunction

   function automatic window_pair predict_pair(input logic signed [DATA_W-1:0] s0,
                                               input logic signed [DATA_W-1:0] s1,
                                               input logic signed [DATA_W-1:0] wi,
                                               input logic signed [DATA_W-1:0] wj,
                                               input logic eob);
      logic signed [ACC_W-1:0] front_acc;
      logic signed [ACC_W-1:0] back_acc;
      window_pair p;
      // exact sums: 66 bits hold every product pair plus the rounding term
      front_acc = (s0 * wj - s1 * wi + ROUND_Q31) >>> Q31_SHIFT;
      back_acc  = (s0 * wi + s1 * wj + ROUND_Q31) >>> Q31_SHIFT;
      p.front = scale_result(front_acc);
      p.back  = scale_result(back_acc);
      p.eob   = eob;
      return p;
   endfunction

   function automatic logic [DATA_W-1:0] rand_q31();
      logic signed [DATA_W-1:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v = Q31_MIN;
         1: v = Q31_MAX;
         2: v = '0;
         3, 4, 5: v = v >>> $urandom_range(1, DATA_W - 1);
         default: ;
      endcase
      return v;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_pair(input logic [DATA_W-1:0] s0, input logic [DATA_W-1:0] s1,
                            input logic [DATA_W-1:0] wi, input logic [DATA_W-1:0] wj,
                            input logic eob);
      int gap;
      int pick;
      @(negedge clock);
      req_valid          <= 1'b1;
      req_first_sample   <= s0;
      req_second_sample  <= s1;
      req_window_rising  <= wi;
      req_window_falling <= wj;
      req_end_of_block   <= eob;
      do @(posedge clock); while (req_stall);
      expected_pairs.push_back(predict_pair(s0, s1, wi, wj, eob));
      pairs_sent++;
      if (cfg_scaled)
         scaled_sent++;
      gap = 0;
      if (sender_gaps_on) begin
         pick = $urandom_range(0, 99);
         if (pick >= 95)
            gap = $urandom_range(8, 30);
         else if (pick >= 60)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold the input side idle until every word has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SCALED_MODE:  cfg_scaled = value[0];
         CSR_OUTPUT_SHIFT: cfg_shift = value[SHIFT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic scaled, input logic [SHIFT_W-1:0] shift);
      wait_drained();
      // upper bits of the mode word are don't-care
      write_register(CSR_SCALED_MODE, {4'($urandom_range(0, 15)), scaled});
      write_register(CSR_OUTPUT_SHIFT, shift);
      settings_used++;
   endtask

   task automatic send_directed(input logic [DATA_W-1:0] s0, input logic [DATA_W-1:0] s1,
                                input logic [DATA_W-1:0] wi, input logic [DATA_W-1:0] wj);
      block_slot++;
      send_pair(s0, s1, wi, wj, block_slot[0]);
   endtask

   task automatic test_unscaled_extremes();
      // first words run on the reset register values
      send_directed('0, '0, '0, '0);
      send_directed(Q31_MIN, Q31_MIN, Q31_MIN, Q31_MIN);
      send_directed(Q31_MAX, Q31_MAX, Q31_MAX, Q31_MAX);
      send_directed(Q31_MAX, Q31_MIN, Q31_MAX, Q31_MIN);
      send_directed(Q31_MIN, Q31_MAX, Q31_MIN, Q31_MAX);
      send_directed('1, '1, '1, '1);
      // rounding term lands exactly on the half
      send_directed(Q15_ONE, '0, '0, Q15_ONE);
      send_directed(Q15_ONE, '0, '0, -Q15_ONE);
      send_directed(Q31_MIN, Q31_MAX, Q31_MAX, Q31_MIN);
   endtask

   task automatic test_scaled_saturation();
      apply_setting(1'b1, 5'd0);
      send_directed(Q31_MAX, Q31_MAX, Q31_MAX, Q31_MAX);
      send_directed(Q31_MIN, '0, Q31_MAX, '0);
      send_directed(Q15_ONE, '0, '0, Q15_ONE);
      send_directed(Q31_MIN, Q31_MIN, Q31_MIN, Q31_MIN);
      apply_setting(1'b1, 5'd31);
      send_directed(Q31_MAX, Q31_MAX, Q31_MAX, Q31_MAX);
      send_directed(Q31_MIN, Q31_MIN, Q31_MIN, Q31_MIN);
      send_directed(Q31_MIN, Q31_MAX, Q31_MAX, Q31_MAX);
      apply_setting(1'b1, 5'd1);
      send_directed(Q15_ONE, '0, '0, Q15_ONE);
      send_directed(Q15_ONE, '0, '0, -(Q15_ONE << 1));
      send_directed(Q15_ONE, Q15_ONE, 32'h0001_8000, 32'h0001_8000);
      apply_setting(1'b0, 5'd31);
      send_directed(Q31_MAX, Q31_MIN, Q31_MIN, Q31_MAX);
   endtask

   task automatic test_random_settings();
      logic [SHIFT_W:0] setting_list[8];
      int left;
      int len;
      bit noise;
      setting_list = '{{1'b0, 5'd0}, {1'b1, 5'd0}, {1'b1, 5'd31}, {1'b0, 5'd31},
                       {1'b1, 5'd1}, {1'b1, 5'd16}, 6'($urandom), 6'($urandom)};
      foreach (setting_list[i]) begin
         apply_setting(setting_list[i][SHIFT_W], setting_list[i][SHIFT_W-1:0]);
         left = 100;
         while (left > 0) begin
            // some blocks run with one or both sides never idling
            sender_gaps_on = ($urandom_range(0, 99) >= 15);
            stall_gaps_on  = ($urandom_range(0, 99) >= 15);
            len = $urandom_range(1, 16);
            if (len > left)
               len = left;
            noise = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
               send_pair(rand_q31(), rand_q31(), rand_q31(), rand_q31(),
                         noise ? 1'($urandom) : (k == len - 1));
            end
            left -= len;
         end
      end
      sender_gaps_on = 1'b1;
      stall_gaps_on  = 1'b1;
   endtask

   task automatic test_pause_until_drained();
      int len;
      apply_setting(1'b1, 5'($urandom_range(8, 20)));
      repeat (4) begin
         len = $urandom_range(5, 20);
         for (int k = 0; k < len; k++)
            send_pair(rand_q31(), rand_q31(), rand_q31(), rand_q31(), k == len - 1);
         wait_drained();
      end
   endtask

   // result side stall: mostly short, now and then long
   initial begin
      int stall_left;
      int pick;
      stall_left = 0;
      do @(negedge clock); while (reset);
      forever begin
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (stall_gaps_on && $urandom_range(0, 99) < 25) begin
            pick = $urandom_range(0, 99);
            stall_left = (pick >= 90) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      window_pair want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pairs.size() == 0) begin
            report_error($sformatf("result word with nothing pending: front %h back %h",
                                   rsp_out_front, rsp_out_back));
         end else begin
            want = expected_pairs.pop_front();
            pairs_checked++;
            if (rsp_out_front !== want.front)
               report_error($sformatf("out_front %h, predicted %h", rsp_out_front, want.front));
            if (rsp_out_back !== want.back)
               report_error($sformatf("out_back %h, predicted %h", rsp_out_back, want.back));
            if (rsp_end_of_block_out !== want.eob)
               report_error($sformatf("end_of_block_out %b, predicted %b",
                                      rsp_end_of_block_out, want.eob));
         end
      end
   end

   initial begin
      #8_000_000;
      $display("ERROR: run timed out with %0d results pending", expected_pairs.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_first_sample   = '0;
      req_second_sample  = '0;
      req_window_rising  = '0;
      req_window_falling = '0;
      req_end_of_block   = 1'b0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = CSR_SCALED_MODE;
      csr_wdata          = '0;
      cfg_scaled         = 1'b0;
      cfg_shift          = '0;
      sender_gaps_on     = 1'b1;
      stall_gaps_on      = 1'b1;
      error_count        = 0;
      pairs_sent         = 0;
      scaled_sent        = 0;
      pairs_checked      = 0;
      settings_used      = 1;
      block_slot         = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_unscaled_extremes();
      test_scaled_saturation();
      test_random_settings();
      test_pause_until_drained();

      stall_gaps_on = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;
      for (int n = 0; n < 20000 && expected_pairs.size() != 0; n++)
         @(posedge clock);
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (expected_pairs.size() != 0)
         report_error($sformatf("%0d predicted results never arrived", expected_pairs.size()));
      $display("Sent %0d window pairs (%0d in scaled mode) over %0d register settings,",
               pairs_sent, scaled_sent, settings_used);
      $display("checked %0d result words with random gaps and stalls on both sides.",
               pairs_checked);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
